// ===== sv/esclu_pkg.sv =====
// Shared types, constants and helpers for the encoder countdown lock.
// No dependencies; imported by every module of the block.
package esclu_pkg;

    localparam int unsigned SPM_W     = 4;
    localparam int unsigned MIN_W     = 10;
    localparam int unsigned ACC_W     = 5;
    localparam int unsigned SEC_W     = 16;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;

    localparam logic [SPM_W-1:0] SPM_RESET     = 4'd5;
    localparam logic [MIN_W-1:0] MAX_RESET     = 10'd999;
    localparam logic [MIN_W-1:0] MINUTES_CAP   = 10'd999;
    localparam logic [SEC_W-1:0] SECS_PER_MIN  = 16'd60;
    localparam logic [SEC_W:0]   ROUND_UP_ADD  = 17'd59;

    // Register index, taken from paddr[2]
    localparam logic REG_SPM = 1'b0;
    localparam logic REG_MAX = 1'b1;

    typedef enum logic [1:0] {
        FUNC_STEP  = 2'd0,
        FUNC_PRESS = 2'd1,
        FUNC_TICK  = 2'd2
    } t_func;

    typedef struct packed {
        logic [SPM_W-1:0] steps_per_minute;
        logic [MIN_W-1:0] max_minutes;
    } t_cfg;

    typedef struct packed {
        logic             locked;
        logic [MIN_W-1:0] shown_minutes;
        logic             expired;
    } t_result;

    // Remaining seconds rounded up to whole minutes: (s + 59) / 60.
    // Divide by 4 with a shift, then by 15 through a reciprocal:
    // 34953 / 2^19 overshoots 1/15 by less than 1/32 over a 15-bit range,
    // which never carries past the next integer.
    function automatic logic [MIN_W-1:0] round_up_minutes(input logic [SEC_W-1:0] secs);
        logic [SEC_W:0]   sum;
        logic [SEC_W-2:0] quarter;
        logic [30:0]      prod;
        sum      = {1'b0, secs} + ROUND_UP_ADD;
        quarter  = sum[SEC_W:2];
        prod     = 31'(quarter) * 31'd34953;
        return prod[19 +: MIN_W];
    endfunction

endpackage

// ===== sv/esclu_cfg_regs.sv =====
// Configuration registers behind an APB-style port.
// Depends on esclu_pkg for the register map and the t_cfg struct.
module esclu_cfg_regs
    import esclu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [SPM_W-1:0] r_spm;
    logic [MIN_W-1:0] r_max;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm <= SPM_RESET;
            r_max <= MAX_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_SPM: r_spm <= pwdata[SPM_W-1:0];
                REG_MAX: r_max <= pwdata[MIN_W-1:0];
                default: r_spm <= r_spm;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SPM: prdata = DATA_W'(r_spm);
            REG_MAX: prdata = DATA_W'(r_max);
            default: prdata = '0;
        endcase
    end

    assign o_cfg.steps_per_minute = r_spm;
    assign o_cfg.max_minutes      = r_max;

endmodule

// ===== sv/esclu_core.sv =====
// Lock state and its next-state logic; forms the result of one event.
// Depends on esclu_pkg for t_cfg, t_result, event codes and rounding.
module esclu_core
    import esclu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_advance,
    input  logic [1:0] i_func,
    input  logic       i_turn_ccw,
    output t_result    o_result,
    output logic       o_locked_state
);

    logic                    r_locked, n_locked;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [MIN_W-1:0]        r_set, n_set;
    logic [SEC_W-1:0]        r_secs, n_secs;
    logic                    n_expired;

    logic signed [ACC_W-1:0] acc_inc, acc_dec, spm_pos, spm_neg;
    logic [MIN_W-1:0]        upper;

    assign spm_pos = $signed({1'b0, i_cfg.steps_per_minute});
    assign spm_neg = -spm_pos;
    assign acc_inc = r_acc + 5'sd1;
    assign acc_dec = r_acc - 5'sd1;
    assign upper   = (i_cfg.max_minutes > MINUTES_CAP) ? MINUTES_CAP : i_cfg.max_minutes;

    always_comb begin
        n_locked  = r_locked;
        n_acc     = r_acc;
        n_set     = r_set;
        n_secs    = r_secs;
        n_expired = 1'b0;
        case (i_func)
            FUNC_STEP: begin
                if (!r_locked) begin
                    if (!i_turn_ccw) begin
                        n_acc = acc_inc;
                        if (acc_inc >= spm_pos) begin
                            n_acc = '0;
                            if (r_set < upper) n_set = r_set + 1'b1;
                        end
                    end else begin
                        n_acc = acc_dec;
                        if (acc_dec <= spm_neg) begin
                            n_acc = '0;
                            if (r_set != '0) n_set = r_set - 1'b1;
                        end
                    end
                end
            end
            FUNC_PRESS: begin
                if (!r_locked && r_set != '0) begin
                    n_secs   = SEC_W'(SEC_W'(r_set) * SECS_PER_MIN);
                    n_locked = 1'b1;
                end
            end
            FUNC_TICK: begin
                if (r_locked) begin
                    if (r_secs != '0) begin
                        n_secs = r_secs - 1'b1;
                    end else begin
                        n_locked  = 1'b0;
                        n_set     = '0;
                        n_secs    = '0;
                        n_expired = 1'b1;
                    end
                end
            end
            default: n_expired = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= 1'b0;
            r_acc    <= '0;
            r_set    <= '0;
            r_secs   <= '0;
        end else if (i_advance) begin
            r_locked <= n_locked;
            r_acc    <= n_acc;
            r_set    <= n_set;
            r_secs   <= n_secs;
        end
    end

    assign o_result.locked        = n_locked;
    assign o_result.shown_minutes = n_locked ? round_up_minutes(n_secs) : n_set;
    assign o_result.expired       = n_expired;
    assign o_locked_state         = r_locked;

endmodule

// ===== sv/encoder_set_countdown_lock_unit.sv =====
// Top level of the encoder countdown lock: event input register, core, result register.
// Depends on esclu_pkg, esclu_cfg_regs and esclu_core.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  events   | i_valid / o_stall       | i_func, i_turn_ccw
//  results  | o_valid / i_stall       | o_locked, o_shown_minutes, o_expired
//  config   | psel, penable, pwrite   | paddr, pwdata, prdata, pready (always 1)
//
// One event per cycle sustained while i_stall is low. An accepted event waits in
// the input register; the core applies it at the edge that writes its result into
// the result register and raises o_valid. A result-side stall can hold it there.
// Reset (synchronous, active low) unlocks, clears minutes, seconds and the
// step accumulator, and loads 5 steps per minute and 999 maximum minutes.
// A stall on the result side backs up through both registers; o_stall rises
// only when both hold a transaction and the result is not being taken.
module encoder_set_countdown_lock_unit
    import esclu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // event transactions
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_func,
    input  logic              i_turn_ccw,
    // result transactions
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_locked,
    output logic [MIN_W-1:0]  o_shown_minutes,
    output logic              o_expired,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg       cfg;
    t_result    core_res;
    logic       core_locked;

    logic       r_in_valid;
    logic [1:0] r_func;
    logic       r_ccw;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       advance;
    logic       in_load;

    esclu_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Result register can take a new transaction when empty or being drained
    assign out_free = !r_out_valid || !i_stall;
    // Apply the held event to the lock state when its result has a place
    assign advance  = r_in_valid && out_free;
    assign in_load  = i_valid && !o_stall;
    assign o_stall  = r_in_valid && !out_free;

    esclu_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_advance      (advance),
        .i_func         (r_func),
        .i_turn_ccw     (r_ccw),
        .o_result       (core_res),
        .o_locked_state (core_locked)
    );

    // Input register: hold the event until the core consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_func <= i_func;
            r_ccw  <= i_turn_ccw;
        end
    end

    // Result register: hold while stalled, refill on advance, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_locked        = r_out.locked;
    assign o_shown_minutes = r_out.shown_minutes;
    assign o_expired       = r_out.expired;

`ifndef SYNTHESIS
    // An expiry result always reports the unlocked state with cleared minutes
    a_expired_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && o_expired |-> !o_locked && o_shown_minutes == '0)
        else $error("expiry result not unlocked with zero minutes");

    // A newly written result reports the lock state the core keeps afterwards
    a_lock_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_locked == core_locked)
        else $error("result lock bit differs from core state");

    // Input side stalls only when the input register holds a transaction
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("stall raised with empty input register");
`endif

endmodule
